FILE: rtl/core/crp_pkg.sv
// ============================================================================
// Clock page replacement package
// Shared constants, codes, slot entry type and hand arithmetic for the
// second-chance clock replacement block.
// ============================================================================
package crp_pkg;

  // Number of frame slots tracked, and derived widths.
  localparam int FRAMES = 8;
  localparam int SLOT_W = 3;                    // slot and hand width
  localparam int CNT_W  = $clog2(FRAMES + 1);   // resident slot count width

  // Operation codes.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_FILL    = 2'd2;
  localparam logic [1:0] OP_REPLACE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_WRONG = 2'd2;

  // Per-slot bookkeeping bits.
  typedef struct packed {
    logic resident;
    logic referenced;
    logic modified;
  } entry_t;

  // Advance the clock hand by one slot, wrapping at the last slot.
  function automatic logic [SLOT_W-1:0] hand_adv(input logic [SLOT_W-1:0] h);
    logic [SLOT_W-1:0] nxt;
    if (h == SLOT_W'(FRAMES - 1)) begin
      nxt = '0;
    end else begin
      nxt = h + SLOT_W'(1);
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/core/clock_page_replacement_top.sv
// ============================================================================
// Clock page replacement
// Tracks resident, referenced and modified bits per frame slot in a small
// synchronous memory and walks a clock hand over it to choose eviction victims.
// ============================================================================
// Read, write and fill pass through an access state that updates the slot
// entry before the result; a replace with nothing resident goes straight to
// the result, and any other replace walks the hand over at most 2*FRAMES slots
// plain or 4*FRAMES enhanced. Throughput: one item at a time; in_ready returns
// together with out_valid, even while that result still waits for out_ready.
// Reset clears all slot entries through per-entry valid flags; clock_mode is 0.
module clock_page_replacement_top (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_clock_mode,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [2:0] in_slot,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_victim_slot,
  output logic       out_victim_dirty,
  output logic [1:0] out_status
);

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       mode_r, mode_nxt;
  logic       clean_r, clean_nxt;
  logic [1:0] op_r, op_nxt;
  logic [crp_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [crp_pkg::SLOT_W-1:0] hand_r, hand_nxt;
  logic [crp_pkg::SLOT_W-1:0] step_r, step_nxt;
  logic [crp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [crp_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic       res_dirty_r, res_dirty_nxt;
  logic [1:0] res_status_r, res_status_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [crp_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic       out_dirty_r, out_dirty_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  // Slot memory and its per-entry valid flags.
  crp_pkg::entry_t mem_q [crp_pkg::FRAMES];
  logic [crp_pkg::FRAMES-1:0] vld_r;
  crp_pkg::entry_t rd_q;
  logic            rd_vld_q;
  crp_pkg::entry_t cur;

  logic                       rd_en;
  logic [crp_pkg::SLOT_W-1:0] rd_addr;
  logic                       wr_en;
  logic [crp_pkg::SLOT_W-1:0] wr_addr;
  crp_pkg::entry_t            wr_data;

  logic                       slot_ok;
  logic                       hit;
  logic [crp_pkg::SLOT_W-1:0] hand_step;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= vld_r[rd_addr];
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign cur       = rd_vld_q ? rd_q : '0;
  assign slot_ok   = {1'b0, slot_r} < crp_pkg::CNT_W'(crp_pkg::FRAMES);
  assign hand_step = crp_pkg::hand_adv(hand_r);
  assign hit       = cur.resident && !cur.referenced && (!clean_r || !cur.modified);

  assign cfg_ready = 1'b1;

  // Sequencer: access update, victim walk and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    clean_nxt      = clean_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    hand_nxt       = hand_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    res_slot_nxt   = res_slot_r;
    res_dirty_nxt  = res_dirty_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slot_nxt   = out_slot_r;
    out_dirty_nxt  = out_dirty_r;
    out_status_nxt = out_status_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = hand_r;
    wr_en          = 1'b0;
    wr_addr        = hand_r;
    wr_data        = '0;

    if (cfg_valid) begin
      mode_nxt = cfg_clock_mode;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt   = in_operation;
          slot_nxt = in_slot;
          if (in_operation != crp_pkg::OP_REPLACE) begin
            rd_en     = 1'b1;
            rd_addr   = in_slot;
            state_nxt = S_ACC;
          end else if (cnt_r == '0) begin
            res_slot_nxt   = '0;
            res_dirty_nxt  = 1'b0;
            res_status_nxt = crp_pkg::ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = hand_r;
            clean_nxt = mode_r;
            step_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_ACC: begin
        res_slot_nxt   = '0;
        res_dirty_nxt  = 1'b0;
        res_status_nxt = crp_pkg::ST_OK;
        wr_addr        = slot_r;
        if (op_r == crp_pkg::OP_FILL) begin
          if (slot_ok && !cur.resident) begin
            wr_en   = 1'b1;
            wr_data = '{resident: 1'b1, referenced: 1'b1, modified: 1'b0};
            cnt_nxt = cnt_r + crp_pkg::CNT_W'(1);
          end else begin
            res_status_nxt = crp_pkg::ST_WRONG;
          end
        end else begin
          if (slot_ok && cur.resident) begin
            wr_en   = 1'b1;
            wr_data = '{resident: 1'b1, referenced: 1'b1,
                        modified: cur.modified || (op_r == crp_pkg::OP_WRITE)};
          end else begin
            res_status_nxt = crp_pkg::ST_WRONG;
          end
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        hand_nxt = hand_step;
        if (hit) begin
          // Victim found: free the slot and stop past it.
          wr_en          = 1'b1;
          wr_data        = '0;
          cnt_nxt        = cnt_r - crp_pkg::CNT_W'(1);
          res_slot_nxt   = hand_r;
          res_dirty_nxt  = cur.modified;
          res_status_nxt = crp_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else begin
          // Second chance: a clearing pass drops the referenced bit.
          if (!clean_r && cur.resident && cur.referenced) begin
            wr_en   = 1'b1;
            wr_data = '{resident: 1'b1, referenced: 1'b0, modified: cur.modified};
          end
          rd_en   = 1'b1;
          rd_addr = hand_step;
          if (step_r == crp_pkg::SLOT_W'(crp_pkg::FRAMES - 1)) begin
            step_nxt = '0;
            if (mode_r) begin
              clean_nxt = !clean_r;
            end
          end else begin
            step_nxt = step_r + crp_pkg::SLOT_W'(1);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_dirty_nxt  = res_dirty_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      clean_r     <= 1'b0;
      hand_r      <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      clean_r     <= clean_nxt;
      hand_r      <= hand_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_dirty_r  <= res_dirty_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_dirty_r  <= out_dirty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_victim_slot  = out_slot_r;
  assign out_victim_dirty = out_dirty_r;
  assign out_status       = out_status_r;

  // The resident count never exceeds the number of slots.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= crp_pkg::CNT_W'(crp_pkg::FRAMES))
    else $error("resident count out of range");

  // A victim walk only runs while some slot is resident.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r != '0))
    else $error("victim walk with no resident slot");

  // A failed operation never reports a victim.
  a_fail_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != crp_pkg::ST_OK))
      |-> (out_slot_r == '0 && !out_dirty_r))
    else $error("victim reported on failed operation");

  // A successful replace always leaves one fewer resident slot.
  a_replace_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (cnt_r == $past(cnt_r) - crp_pkg::CNT_W'(1)))
    else $error("replace did not free a slot");

endmodule

FILE: dv/clock_page_replacement_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement testbench
// Drives access, fill and replace requests into the clock replacement block
// in both plain and enhanced modes and checks every result against a
// cycle-free prediction of the slot bits and the clock hand or a typed result.
// ============================================================================
module clock_page_replacement_top_test;

  localparam int CLK_HALF_NS   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 12;
  localparam int NOISE_PCT     = 15;
  localparam int PHASE_ITEMS   = 232;
  localparam int CALM_ITEMS    = 120;
  localparam int HOLD_CYCLES   = 160;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int PLAN_ROWS     = 27;

  // One result of the block.
  typedef struct packed {
    logic [crp_pkg::SLOT_W-1:0] victim_slot;
    logic                       victim_dirty;
    logic [1:0]                 status;
  } verdict_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_MODE} row_kind_t;

  // One line of the directed plan: an item, or a clock_mode write.
  typedef struct packed {
    row_kind_t                  kind;
    logic [1:0]                 operation;
    logic [crp_pkg::SLOT_W-1:0] slot;
    logic                       mode;
    verdict_t                   want;
  } plan_row_t;

  localparam verdict_t RES_OK    = '{'0, 1'b0, crp_pkg::ST_OK};
  localparam verdict_t RES_EMPTY = '{'0, 1'b0, crp_pkg::ST_EMPTY};
  localparam verdict_t RES_WRONG = '{'0, 1'b0, crp_pkg::ST_WRONG};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_clock_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation = crp_pkg::OP_READ;
  logic [2:0] in_slot = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_victim_slot;
  logic       out_victim_dirty;
  logic [1:0] out_status;

  // Predicted slot bookkeeping, updated at each accepted input transfer.
  logic [crp_pkg::FRAMES-1:0] frame_resident = '0;
  logic [crp_pkg::FRAMES-1:0] frame_used = '0;
  logic [crp_pkg::FRAMES-1:0] frame_dirty = '0;
  logic [crp_pkg::SLOT_W-1:0] hand_pos = '0;
  logic                       enhanced_mode = 1'b0;

  verdict_t  pending_q[$];
  int        mismatch_count = 0;
  int        hold_requests = 0;
  bit        calm = 1'b0;
  plan_row_t directed_plan [PLAN_ROWS];

  clock_page_replacement_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_clock_mode   (cfg_clock_mode),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_victim_slot  (out_victim_slot),
    .out_victim_dirty (out_victim_dirty),
    .out_status       (out_status)
  );

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  function automatic logic [crp_pkg::SLOT_W-1:0] slot_after(
      input logic [crp_pkg::SLOT_W-1:0] s);
    return (int'(s) == crp_pkg::FRAMES - 1) ? '0 : s + 1'b1;
  endfunction

  // One full lap of the hand. A resident slot qualifies when its use bit is clear and,
  // if asked, it is clean. Passed slots may get their use bit cleared.
  function automatic bit hand_lap(input bit want_clean, input bit clear_used,
                                  output logic [crp_pkg::SLOT_W-1:0] victim);
    logic [crp_pkg::SLOT_W-1:0] s;
    victim = '0;
    for (int n = 0; n < crp_pkg::FRAMES; n++) begin
      s = hand_pos;
      hand_pos = slot_after(hand_pos);
      if (frame_resident[s]) begin
        if (!frame_used[s] && (!want_clean || !frame_dirty[s])) begin
          victim = s;
          return 1'b1;
        end
        if (clear_used) begin
          frame_used[s] = 1'b0;
        end
      end
    end
    return 1'b0;
  endfunction

  // Enhanced mode alternates a clean-only lap with a clearing lap.
  function automatic bit choose_victim(output logic [crp_pkg::SLOT_W-1:0] victim);
    victim = '0;
    if (frame_resident == '0) begin
      return 1'b0;
    end
    for (int round = 0; round < 3; round++) begin
      if (enhanced_mode && hand_lap(1'b1, 1'b0, victim)) begin
        return 1'b1;
      end
      if (hand_lap(1'b0, 1'b1, victim)) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic verdict_t apply_request(input logic [1:0] op,
                                             input logic [crp_pkg::SLOT_W-1:0] slot);
    verdict_t v;
    logic [crp_pkg::SLOT_W-1:0] victim;
    bit present;
    v = RES_OK;
    present = int'(slot) < crp_pkg::FRAMES && frame_resident[slot];
    case (op)
      crp_pkg::OP_READ, crp_pkg::OP_WRITE: begin
        if (present) begin
          frame_used[slot] = 1'b1;
          if (op == crp_pkg::OP_WRITE) begin
            frame_dirty[slot] = 1'b1;
          end
        end else begin
          v.status = crp_pkg::ST_WRONG;
        end
      end
      crp_pkg::OP_FILL: begin
        if (int'(slot) < crp_pkg::FRAMES && !present) begin
          frame_resident[slot] = 1'b1;
          frame_used[slot] = 1'b1;
          frame_dirty[slot] = 1'b0;
        end else begin
          v.status = crp_pkg::ST_WRONG;
        end
      end
      default: begin
        if (choose_victim(victim)) begin
          v.victim_slot = victim;
          v.victim_dirty = frame_dirty[victim];
          frame_resident[victim] = 1'b0;
          frame_used[victim] = 1'b0;
          frame_dirty[victim] = 1'b0;
          hand_pos = slot_after(victim);
        end else begin
          v.status = crp_pkg::ST_EMPTY;
        end
      end
    endcase
    return v;
  endfunction

  // Random slot that is resident, or free, as asked. One must exist.
  function automatic logic [crp_pkg::SLOT_W-1:0] pick_slot(input logic resident);
    logic [crp_pkg::SLOT_W-1:0] s;
    s = crp_pkg::SLOT_W'($urandom_range(crp_pkg::FRAMES - 1));
    while (frame_resident[s] != resident) begin
      s = crp_pkg::SLOT_W'($urandom_range(crp_pkg::FRAMES - 1));
    end
    return s;
  endfunction

  // Offers one request and records its expected result once the transfer
  // happens. A typed result replaces the predicted one.
  task automatic offer_item(input logic [1:0] op,
                            input logic [crp_pkg::SLOT_W-1:0] slot,
                            input bit typed, input verdict_t want);
    verdict_t predicted;
    in_valid <= 1'b1;
    in_operation <= op;
    in_slot <= slot;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = apply_request(op, slot);
    pending_q.push_back(typed ? want : predicted);
  endtask

  // Random gaps on the input side, skipped during the calm stretch.
  task automatic sender_gap();
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The mode register is only written once the block has gone idle.
  task automatic write_clock_mode(input logic mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_clock_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    enhanced_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: fills of free slots, accesses to resident
  // slots and replaces, with some fully random requests mixed in.
  task automatic offer_random_item();
    logic [1:0]                 op;
    logic [crp_pkg::SLOT_W-1:0] slot;
    int                         filled;
    int                         roll;
    filled = $countones(frame_resident);
    roll = $urandom_range(99);
    op = crp_pkg::OP_REPLACE;
    slot = crp_pkg::SLOT_W'($urandom_range(7));
    if (roll < NOISE_PCT) begin
      op = 2'($urandom_range(3));
    end else if (filled == 0 || (filled < crp_pkg::FRAMES && roll < 40)) begin
      op = crp_pkg::OP_FILL;
      slot = pick_slot(1'b0);
    end else if (roll < 75) begin
      op = ($urandom_range(1) == 0) ? crp_pkg::OP_READ : crp_pkg::OP_WRITE;
      slot = pick_slot(1'b1);
    end
    offer_item(op, slot, 1'b0, RES_OK);
  endtask

  // Input side: reset, directed plan, then four random phases.
  initial begin : stimulus
    plan_row_t row;
    directed_plan = '{
      '{ROW_MODE,    crp_pkg::OP_READ,    3'd0, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_REPLACE, 3'd0, 1'b0, RES_EMPTY},
      '{ROW_TYPED,   crp_pkg::OP_READ,    3'd0, 1'b0, RES_WRONG},
      '{ROW_TYPED,   crp_pkg::OP_WRITE,   3'd7, 1'b0, RES_WRONG},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd0, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd0, 1'b0, RES_WRONG},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd7, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd3, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_WRITE,   3'd7, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_READ,    3'd3, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd5, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_WRITE,   3'd0, 1'b0, RES_WRONG},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd2, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd7, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_REPLACE, 3'd0, 1'b0, RES_EMPTY},
      '{ROW_MODE,    crp_pkg::OP_READ,    3'd0, 1'b1, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd1, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd2, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd6, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_WRITE,   3'd1, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_WRITE,   3'd2, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd0, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd4, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd3, 1'b0, RES_OK},
      '{ROW_TYPED,   crp_pkg::OP_REPLACE, 3'd0, 1'b0, RES_EMPTY},
      '{ROW_TYPED,   crp_pkg::OP_FILL,    3'd4, 1'b0, RES_OK},
      '{ROW_PREDICT, crp_pkg::OP_REPLACE, 3'd1, 1'b0, RES_OK}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_MODE) begin
        write_clock_mode(row.mode);
      end else begin
        sender_gap();
        offer_item(row.operation, row.slot, row.kind == ROW_TYPED, row.want);
      end
    end

    // Phases alternate plain and enhanced mode. Phase one opens with a calm
    // stretch, phase two holds the result side off for a long while, and
    // phase three stops halfway until every result has come back.
    for (int phase = 0; phase < 4; phase++) begin
      write_clock_mode(phase[0]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm = (phase == 1 && i < CALM_ITEMS);
        if (phase == 2 && i == 40) begin
          hold_requests++;
        end
        if (phase == 3 && i == PHASE_ITEMS / 2) begin
          drain_results();
        end
        sender_gap();
        offer_random_item();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random back-pressure plus the long hold when requested.
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result victim_slot %0d victim_dirty %0d status %0d",
                 $time, out_victim_slot, out_victim_dirty, out_status);
        mismatch_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_victim_slot !== want.victim_slot) begin
          $display("%0t: victim_slot expected %0d actual %0d",
                   $time, want.victim_slot, out_victim_slot);
          mismatch_count++;
        end
        if (out_victim_dirty !== want.victim_dirty) begin
          $display("%0t: victim_dirty expected %0d actual %0d",
                   $time, want.victim_dirty, out_victim_dirty);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/crp_pkg.sv
rtl/core/clock_page_replacement_top.sv
dv/clock_page_replacement_top_test.sv
